/* sv/sm4_block_encrypt_unit_macros.svh */
`ifndef SM4_BLOCK_ENCRYPT_UNIT_MACROS_SVH
`define SM4_BLOCK_ENCRYPT_UNIT_MACROS_SVH

// clocked assertion, off while in reset
`define SM4_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion, also checked during reset
`define SM4_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/sm4_pkg.sv */
package sm4_pkg;

  localparam int unsigned RoundCount = 32;
  localparam int unsigned RoundIdxW  = $clog2(RoundCount);
  localparam int unsigned WordW      = 32;
  localparam int unsigned HalfW      = 64;
  localparam int unsigned CfgIdxW    = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_HI = 1'b0,
    CFG_KEY_LO = 1'b1
  } cfg_reg_e;

  typedef logic [WordW-1:0]      word_t;
  typedef logic [0:3][WordW-1:0] quad_t;

  // k: running key words, x: running data words
  typedef struct packed {
    quad_t k;
    quad_t x;
  } sm4_state_t;

  localparam word_t Fk0 = 32'hA3B1BAC6;
  localparam word_t Fk1 = 32'h56AA3350;
  localparam word_t Fk2 = 32'h677D9197;
  localparam word_t Fk3 = 32'hB27022DC;

  localparam logic [7:0] Sbox [256] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  function automatic word_t rotl(word_t w, int unsigned n);
    return (w << n) | (w >> (WordW - n));
  endfunction

  function automatic word_t tau(word_t w);
    return {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
  endfunction

  function automatic word_t mix_round(word_t w);
    word_t b;
    b = tau(w);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic word_t mix_key(word_t w);
    word_t b;
    b = tau(w);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // byte j of CK[i] is (4i+j)*7 mod 256
  function automatic word_t ck_word(logic [RoundIdxW-1:0] i);
    word_t      w;
    logic [7:0] idx;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      idx = 8'({i, 2'(j)});
      w   = {w[23:0], 8'(idx * 8'd7)};
    end
    return w;
  endfunction

endpackage

/* sv/sm4_plain_if.sv */
interface sm4_plain_if;
  import sm4_pkg::*;

  logic               valid;
  logic               ready;
  logic [HalfW-1:0]   plain_hi;
  logic [HalfW-1:0]   plain_lo;

  modport source (output valid, output plain_hi, output plain_lo, input ready);
  modport sink   (input valid, input plain_hi, input plain_lo, output ready);
endinterface

/* sv/sm4_cipher_if.sv */
interface sm4_cipher_if;
  import sm4_pkg::*;

  logic               valid;
  logic               ready;
  logic [HalfW-1:0]   cipher_hi;
  logic [HalfW-1:0]   cipher_lo;

  modport source (output valid, output cipher_hi, output cipher_lo, input ready);
  modport sink   (input valid, input cipher_hi, input cipher_lo, output ready);
endinterface

/* sv/sm4_round_cell.sv */
`include "sm4_block_encrypt_unit_macros.svh"

module sm4_round_cell import sm4_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  word_t      ck_i,
  input  logic       valid_i,
  output logic       ready_o,
  input  sm4_state_t state_i,
  output logic       valid_o,
  input  logic       ready_i,
  output sm4_state_t state_o
);

  logic       valid_q;
  sm4_state_t state_q, state_d;
  word_t      rk;
  word_t      nx;

  // key step, then data round with the fresh round key
  always_comb begin
    rk = state_i.k[0] ^ mix_key(state_i.k[1] ^ state_i.k[2] ^ state_i.k[3] ^ ck_i);
    nx = state_i.x[0] ^ mix_round(state_i.x[1] ^ state_i.x[2] ^ state_i.x[3] ^ rk);
    state_d.k = {state_i.k[1], state_i.k[2], state_i.k[3], rk};
    state_d.x = {state_i.x[1], state_i.x[2], state_i.x[3], nx};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

  `SM4_ASSERT(a_stall_holds, valid_q && !ready_i |=> valid_q && $stable(state_q), "stalled item changed")
  `SM4_ASSERT(a_take_lands, valid_i && ready_o |=> valid_q, "accepted item lost")
  `SM4_ASSERT(a_words_shift, valid_i && ready_o |=> state_q.x[0] == $past(state_i.x[1]) && state_q.k[0] == $past(state_i.k[1]), "word shift broken")

endmodule

/* sv/sm4_block_encrypt_unit.sv */
// SM4 block encryption, 128-bit key, 32 rounds.
// Channels: plain_i takes one plaintext item (plain_hi, plain_lo) per
// valid/ready handshake; cipher_o returns one ciphertext item for each.
// Key: written through cfg_we_i / cfg_idx_i / cfg_data_i (CFG_KEY_HI,
// CFG_KEY_LO); the user is to do so only while no item is in flight, as
// the block does not enforce it; each item picks up the key as it enters
// and carries its own key schedule along the chain.
// One registered cell per round: a key-schedule step and a round.
// Throughput: one item per cycle while cipher_o.ready is high.
// Reset: clears all item valid flags and sets the key to zero.
// Receiver stall: the last cell holds its item; upstream cells keep
// moving into empty slots, so plain_i.ready drops only once every cell
// in front of a stalled item is occupied.
module sm4_block_encrypt_unit import sm4_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [HalfW-1:0]   cfg_data_i,
  sm4_plain_if.sink          plain_i,
  sm4_cipher_if.source       cipher_o
);

  logic [HalfW-1:0] key_hi_q;
  logic [HalfW-1:0] key_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_KEY_HI: key_hi_q <= cfg_data_i;
        CFG_KEY_LO: key_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic       valid_c [RoundCount+1];
  logic       ready_c [RoundCount+1];
  sm4_state_t state_c [RoundCount+1];

  assign valid_c[0]   = plain_i.valid;
  assign plain_i.ready = ready_c[0];
  assign state_c[0].k = {key_hi_q[63:32] ^ Fk0, key_hi_q[31:0] ^ Fk1,
                         key_lo_q[63:32] ^ Fk2, key_lo_q[31:0] ^ Fk3};
  assign state_c[0].x = {plain_i.plain_hi[63:32], plain_i.plain_hi[31:0],
                         plain_i.plain_lo[63:32], plain_i.plain_lo[31:0]};

  for (genvar r = 0; r < RoundCount; r++) begin : g_round
    sm4_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ck_i    (ck_word(RoundIdxW'(r))),
      .valid_i (valid_c[r]),
      .ready_o (ready_c[r]),
      .state_i (state_c[r]),
      .valid_o (valid_c[r+1]),
      .ready_i (ready_c[r+1]),
      .state_o (state_c[r+1])
    );
  end

  assign ready_c[RoundCount] = cipher_o.ready;
  assign cipher_o.valid      = valid_c[RoundCount];
  assign cipher_o.cipher_hi  = {state_c[RoundCount].x[3], state_c[RoundCount].x[2]};
  assign cipher_o.cipher_lo  = {state_c[RoundCount].x[1], state_c[RoundCount].x[0]};

endmodule

/* tb/sm4_block_encrypt_unit_test.sv */
module sm4_block_encrypt_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned LongHold = 300;
  localparam logic [63:0] Ones = '1;
  localparam logic [63:0] StdHi = 64'h0123456789ABCDEF;
  localparam logic [63:0] StdLo = 64'hFEDCBA9876543210;

  localparam logic [31:0] FkWord [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

  localparam logic [7:0] SboxLut [256] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [sm4_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [sm4_pkg::HalfW-1:0]   cfg_data_i = '0;

  sm4_plain_if  plain_ch ();
  sm4_cipher_if cipher_ch ();

  sm4_block_encrypt_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .plain_i    (plain_ch),
    .cipher_o   (cipher_ch)
  );

  logic [63:0] key_hi_q = '0;
  logic [63:0] key_lo_q = '0;
  block_t      plain_pending_q [$];
  block_t      cipher_expect_q [$];
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          offering;
  block_t      next_plain;
  block_t      want;

  always #4 clk_i = ~clk_i;

  function automatic logic [31:0] rot_left(logic [31:0] w, int n);
    logic [63:0] d;
    d = {w, w};
    return d[(63 - n) -: 32];
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {SboxLut[w[31:24]], SboxLut[w[23:16]], SboxLut[w[15:8]], SboxLut[w[7:0]]};
  endfunction

  // key schedule and data rounds run side by side, one step each per round
  function automatic block_t sm4_encrypt(logic [63:0] khi, logic [63:0] klo, block_t pt);
    logic [31:0] k [4];
    logic [31:0] x [4];
    logic [31:0] ck;
    logic [31:0] b;
    logic [31:0] rk;
    logic [31:0] nx;
    k[0] = khi[63:32] ^ FkWord[0];
    k[1] = khi[31:0] ^ FkWord[1];
    k[2] = klo[63:32] ^ FkWord[2];
    k[3] = klo[31:0] ^ FkWord[3];
    x[0] = pt.hi[63:32];
    x[1] = pt.hi[31:0];
    x[2] = pt.lo[63:32];
    x[3] = pt.lo[31:0];
    for (int r = 0; r < 32; r++) begin
      ck = '0;
      for (int j = 0; j < 4; j++) ck = {ck[23:0], 8'((4 * r + j) * 7)};
      b = sub_word(k[1] ^ k[2] ^ k[3] ^ ck);
      rk = k[0] ^ b ^ rot_left(b, 13) ^ rot_left(b, 23);
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = rk;
      b = sub_word(x[1] ^ x[2] ^ x[3] ^ rk);
      nx = x[0] ^ b ^ rot_left(b, 2) ^ rot_left(b, 10) ^ rot_left(b, 18) ^ rot_left(b, 24);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = nx;
    end
    return block_t'{{x[3], x[2]}, {x[1], x[0]}};
  endfunction

  task automatic write_key(sm4_pkg::cfg_reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == sm4_pkg::CFG_KEY_HI) key_hi_q = val;
    else key_lo_q = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (plain_pending_q.size() != 0 || plain_ch.valid || cipher_expect_q.size() != 0);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      offering = plain_ch.valid && !plain_ch.ready;
      if (plain_ch.valid && plain_ch.ready)
        cipher_expect_q.push_back(sm4_encrypt(key_hi_q, key_lo_q,
                                              block_t'{plain_ch.plain_hi, plain_ch.plain_lo}));
      if (!offering) begin
        if (send_wait > 0) begin
          plain_ch.valid <= 1'b0;
          send_wait--;
        end else if (plain_pending_q.size() > 0) begin
          next_plain = plain_pending_q.pop_front();
          plain_ch.valid    <= 1'b1;
          plain_ch.plain_hi <= next_plain.hi;
          plain_ch.plain_lo <= next_plain.lo;
          send_wait = send_idle ? $urandom_range(0, 9) : 0;
        end else begin
          plain_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cipher_ch.valid && cipher_ch.ready) begin
        results_seen++;
        if (cipher_expect_q.size() == 0) begin
          $display("%0t: unexpected item, expected none got %h %h", $time,
                   cipher_ch.cipher_hi, cipher_ch.cipher_lo);
          error_count++;
        end else begin
          want = cipher_expect_q.pop_front();
          if (cipher_ch.cipher_hi !== want.hi) begin
            $display("%0t: cipher_hi expected %h got %h", $time, want.hi, cipher_ch.cipher_hi);
            error_count++;
          end
          if (cipher_ch.cipher_lo !== want.lo) begin
            $display("%0t: cipher_lo expected %h got %h", $time, want.lo, cipher_ch.cipher_lo);
            error_count++;
          end
        end
        recv_wait = recv_idle ? $urandom_range(0, 9) : 0;
        // long back-pressure so the pipe fills and stalls its input
        if (results_seen == 40 || results_seen == 500) recv_wait = LongHold;
      end
      if (recv_wait > 0) begin
        cipher_ch.ready <= 1'b0;
        recv_wait--;
      end else begin
        cipher_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("sm4_block_encrypt_unit test failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] khi;
    logic [63:0] klo;
    plain_ch.valid    = 1'b0;
    plain_ch.plain_hi = '0;
    plain_ch.plain_lo = '0;
    cipher_ch.ready   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // key left at its reset value
    plain_pending_q.push_back(block_t'{64'h0, 64'h0});
    plain_pending_q.push_back(block_t'{Ones, Ones});
    plain_pending_q.push_back(block_t'{64'h8000000000000000, 64'h0});
    plain_pending_q.push_back(block_t'{64'h0, 64'h1});
    plain_pending_q.push_back(block_t'{64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA});
    plain_pending_q.push_back(block_t'{StdHi, StdLo});
    wait_drained();

    // published test vector key
    write_key(sm4_pkg::CFG_KEY_HI, StdHi);
    write_key(sm4_pkg::CFG_KEY_LO, StdLo);
    @(negedge clk_i);
    plain_pending_q.push_back(block_t'{StdHi, StdLo});
    plain_pending_q.push_back(block_t'{64'h0, 64'h0});
    plain_pending_q.push_back(block_t'{Ones, Ones});
    plain_pending_q.push_back(block_t'{64'h1, 64'h8000000000000000});
    wait_drained();

    write_key(sm4_pkg::CFG_KEY_HI, Ones);
    write_key(sm4_pkg::CFG_KEY_LO, Ones);
    @(negedge clk_i);
    plain_pending_q.push_back(block_t'{64'h0, 64'h0});
    plain_pending_q.push_back(block_t'{Ones, Ones});
    plain_pending_q.push_back(block_t'{64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555});
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      khi = {$urandom, $urandom};
      klo = {$urandom, $urandom};
      if (ph == 3) begin
        khi = '0;
        klo = Ones;
      end else if (ph == 6) begin
        khi = Ones;
        klo = '0;
      end
      write_key(sm4_pkg::CFG_KEY_HI, khi);
      write_key(sm4_pkg::CFG_KEY_LO, klo);
      @(negedge clk_i);
      send_idle = (ph % 4 == 0) || (ph % 4 == 2);
      recv_idle = (ph % 4 == 0) || (ph % 4 == 3);
      for (int n = 0; n < 125; n++)
        plain_pending_q.push_back(block_t'{{$urandom, $urandom}, {$urandom, $urandom}});
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && cipher_expect_q.size() == 0) begin
      $display("sm4_block_encrypt_unit test passed");
    end else begin
      $display("sm4_block_encrypt_unit test failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/sm4_pkg.sv
sv/sm4_plain_if.sv
sv/sm4_cipher_if.sv
sv/sm4_round_cell.sv
sv/sm4_block_encrypt_unit.sv
tb/sm4_block_encrypt_unit_test.sv
